// ----- design/quality_tail_trim_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the quality tail trimmer
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef QUALITY_TAIL_TRIM_ASSERT_SVH
`define QUALITY_TAIL_TRIM_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define QTT_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("quality_tail_trim: assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define QTT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("quality_tail_trim: assertion failed");

`endif

// ----- design/qtt_pkg.sv -----
// ----------------------------------------------------------------------------
// qtt_pkg
// Shared constants for the quality tail trimmer.
// ----------------------------------------------------------------------------
`default_nettype none

package qtt_pkg;

    localparam int QTT_MAX_READ_LEN = 1024;

    localparam int QUAL_W   = 8;
    localparam int THR_W    = 7;
    localparam int KEEP_W   = 11;
    localparam int SUM_W    = 18;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 11;

    localparam logic [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic [SUM_W:0] PHRED_OFFSET = (SUM_W+1)'(33);

    localparam logic [CFG_IDX_W-1:0] REG_QUALITY_THRESHOLD = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_KEEP_LENGTH   = 1'd1;

endpackage

`default_nettype wire

// ----- design/quality_tail_trim.sv -----
// Flow: after a read's last byte the scan steps over n bytes and the result is
//   registered, n being the bytes scanned (at most the stored length, none
//   when the minimum length reaches the read length).
// Throughput: one byte per cycle in unless the request queue is full; the scan
//   unit does start, n scan steps and result handoff, one stored byte a cycle.
// Reset: control state clears at once; the store needs no clearing pass.
// ----------------------------------------------------------------------------
// quality_tail_trim
// Phred quality tail trimmer: stores each read's quality bytes and, once its
// last byte is in, scans backward to find the kept length.
// ----------------------------------------------------------------------------
`default_nettype none

module quality_tail_trim
    import qtt_pkg::*;
#(
    parameter int MAX_READ_LEN = QTT_MAX_READ_LEN
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // Configuration write port.
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    // Input request channel: one quality byte per request.
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire logic [QUAL_W-1:0]     qual_byte,
    input  wire logic                  last,
    // Output request channel: one result per read.
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic      [KEEP_W-1:0]     keep_length,
    output logic                       too_long
);

    localparam int PW = $clog2(MAX_READ_LEN);
    localparam int LW = $clog2(MAX_READ_LEN + 1);

    // The store is split into two banks of MAX_READ_LEN bytes. The front
    // fills one bank while the back scans the other, and the two-entry
    // request queue tracks which banks hold a finished read. The front stops
    // taking bytes only when both banks wait for the scan.

    logic [THR_W-1:0]  thr_reg, thr_next;
    logic [KEEP_W-1:0] min_keep_reg, min_keep_next;

    logic              q_full;
    logic              push;
    logic              push_bank;
    logic [LW-1:0]     push_len;
    logic              push_ovf;
    logic              pop;
    logic              head_valid;
    logic              head_bank;
    logic [LW-1:0]     head_len;
    logic              head_ovf;
    logic              wr_en;
    logic [PW:0]       wr_addr;
    logic [QUAL_W-1:0] wr_data;
    logic [PW:0]       rd_addr;
    logic [QUAL_W-1:0] rd_data;

    // Configuration registers; writes beyond the register list are ignored.
    always_comb
    begin
        thr_next      = thr_reg;
        min_keep_next = min_keep_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_QUALITY_THRESHOLD: thr_next      = cfg_data[THR_W-1:0];
                REG_MIN_KEEP_LENGTH:   min_keep_next = cfg_data[KEEP_W-1:0];
                default:
                begin
                    thr_next      = thr_reg;
                    min_keep_next = min_keep_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg      <= '0;
            min_keep_reg <= '0;
        end
        else
        begin
            thr_reg      <= thr_next;
            min_keep_reg <= min_keep_next;
        end
    end

    // Front: takes bytes, writes the store and queues a scan per read.
    qtt_front #(
        .MAX_READ_LEN (MAX_READ_LEN)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .qual_byte (qual_byte),
        .last      (last),
        .q_full    (q_full),
        .push      (push),
        .push_bank (push_bank),
        .push_len  (push_len),
        .push_ovf  (push_ovf),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data)
    );

    // Queue of finished reads waiting for the scan.
    qtt_queue #(
        .MAX_READ_LEN (MAX_READ_LEN)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_bank  (push_bank),
        .push_len   (push_len),
        .push_ovf   (push_ovf),
        .pop        (pop),
        .full       (q_full),
        .head_valid (head_valid),
        .head_bank  (head_bank),
        .head_len   (head_len),
        .head_ovf   (head_ovf)
    );

    // Quality byte store.
    qtt_mem #(
        .MAX_READ_LEN (MAX_READ_LEN)
    ) u_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Back: the backward scan and the result register.
    qtt_back #(
        .MAX_READ_LEN (MAX_READ_LEN)
    ) u_back (
        .clk               (clk),
        .rst_n             (rst_n),
        .quality_threshold (thr_reg),
        .min_keep_length   (min_keep_reg),
        .head_valid        (head_valid),
        .head_bank         (head_bank),
        .head_len          (head_len),
        .head_ovf          (head_ovf),
        .pop               (pop),
        .rd_addr           (rd_addr),
        .rd_data           (rd_data),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .keep_length       (keep_length),
        .too_long          (too_long)
    );

endmodule

`default_nettype wire

// ----- design/qtt_mem.sv -----
// ----------------------------------------------------------------------------
// qtt_mem
// Two-bank quality byte store: one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module qtt_mem
    import qtt_pkg::*;
#(
    parameter int MAX_READ_LEN = QTT_MAX_READ_LEN,
    localparam int PW = $clog2(MAX_READ_LEN),
    localparam int DEPTH = 2 ** (PW + 1)
)
(
    input  wire logic              clk,
    input  wire logic              wr_en,
    input  wire logic [PW:0]       wr_addr,
    input  wire logic [QUAL_W-1:0] wr_data,
    input  wire logic [PW:0]       rd_addr,
    output logic      [QUAL_W-1:0] rd_data
);

    logic [QUAL_W-1:0] store_mem [DEPTH];
    logic [QUAL_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            store_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data_reg <= store_mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ----- design/qtt_front.sv -----
// ----------------------------------------------------------------------------
// qtt_front
// Accepts quality bytes, writes them to the current bank and queues a scan
// request when the last byte of a read arrives.
// ----------------------------------------------------------------------------
`default_nettype none

module qtt_front
    import qtt_pkg::*;
#(
    parameter int MAX_READ_LEN = QTT_MAX_READ_LEN,
    localparam int PW = $clog2(MAX_READ_LEN),
    localparam int LW = $clog2(MAX_READ_LEN + 1)
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [QUAL_W-1:0] qual_byte,
    input  wire logic              last,
    input  wire logic              q_full,
    output logic                   push,
    output logic                   push_bank,
    output logic      [LW-1:0]     push_len,
    output logic                   push_ovf,
    output logic                   wr_en,
    output logic      [PW:0]       wr_addr,
    output logic      [QUAL_W-1:0] wr_data
);

`include "quality_tail_trim_assert.svh"

    localparam logic [LW-1:0] MAX_LEN = LW'(MAX_READ_LEN);

    logic [LW-1:0] fill_reg, fill_next;
    logic          ovf_reg, ovf_next;
    logic          bank_reg, bank_next;
    logic          accept;
    logic          room;
    logic [LW-1:0] fill_inc;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;
    assign room     = (fill_reg < MAX_LEN);
    assign fill_inc = room ? (fill_reg + LW'(1)) : fill_reg;

    assign wr_en   = accept && room;
    assign wr_addr = {bank_reg, fill_reg[PW-1:0]};
    assign wr_data = qual_byte;

    assign push      = accept && last;
    assign push_bank = bank_reg;
    assign push_len  = fill_inc;
    assign push_ovf  = ovf_reg || !room;

    always_comb
    begin
        fill_next = fill_reg;
        ovf_next  = ovf_reg;
        bank_next = bank_reg;
        if (accept)
        begin
            if (last)
            begin
                fill_next = '0;
                ovf_next  = 1'b0;
                bank_next = !bank_reg;
            end
            else
            begin
                fill_next = fill_inc;
                ovf_next  = ovf_reg || !room;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
            ovf_reg  <= 1'b0;
            bank_reg <= 1'b0;
        end
        else
        begin
            fill_reg <= fill_next;
            ovf_reg  <= ovf_next;
            bank_reg <= bank_next;
        end
    end

    `QTT_ASSERT_NOW(a_fill_bounded, 1'b1, fill_reg <= MAX_LEN)
    `QTT_ASSERT_NOW(a_ovf_only_full, ovf_reg, fill_reg == MAX_LEN)
    `QTT_ASSERT_NEXT(a_bank_flips, push, bank_reg != $past(bank_reg))

endmodule

`default_nettype wire

// ----- design/qtt_queue.sv -----
// ----------------------------------------------------------------------------
// qtt_queue
// Two-entry queue of scan requests, one per store bank.
// ----------------------------------------------------------------------------
`default_nettype none

module qtt_queue
    import qtt_pkg::*;
#(
    parameter int MAX_READ_LEN = QTT_MAX_READ_LEN,
    localparam int LW = $clog2(MAX_READ_LEN + 1)
)
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire logic          push_bank,
    input  wire logic [LW-1:0] push_len,
    input  wire logic          push_ovf,
    input  wire logic          pop,
    output logic               full,
    output logic               head_valid,
    output logic               head_bank,
    output logic      [LW-1:0] head_len,
    output logic               head_ovf
);

`include "quality_tail_trim_assert.svh"

    logic          bank_q [2];
    logic [LW-1:0] len_q  [2];
    logic          ovf_q  [2];
    logic          wr_ptr_reg, wr_ptr_next;
    logic          rd_ptr_reg, rd_ptr_next;
    logic [1:0]    count_reg, count_next;

    assign full       = (count_reg == 2'd2);
    assign head_valid = (count_reg != 2'd0);
    assign head_bank  = bank_q[rd_ptr_reg];
    assign head_len   = len_q[rd_ptr_reg];
    assign head_ovf   = ovf_q[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            bank_q[wr_ptr_reg] <= push_bank;
            len_q[wr_ptr_reg]  <= push_len;
            ovf_q[wr_ptr_reg]  <= push_ovf;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    `QTT_ASSERT_NOW(a_no_push_full, push, !full)
    `QTT_ASSERT_NOW(a_no_pop_empty, pop, head_valid)
    `QTT_ASSERT_NOW(a_count_ptrs, count_reg == 2'd1, wr_ptr_reg != rd_ptr_reg)

endmodule

`default_nettype wire

// ----- design/qtt_back.sv -----
// ----------------------------------------------------------------------------
// qtt_back
// Backward scan engine: one stored byte per cycle, then the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module qtt_back
    import qtt_pkg::*;
#(
    parameter int MAX_READ_LEN = QTT_MAX_READ_LEN,
    localparam int PW = $clog2(MAX_READ_LEN),
    localparam int LW = $clog2(MAX_READ_LEN + 1),
    localparam int CMPW = (LW > KEEP_W) ? LW : KEEP_W
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic [THR_W-1:0]  quality_threshold,
    input  wire logic [KEEP_W-1:0] min_keep_length,
    input  wire logic              head_valid,
    input  wire logic              head_bank,
    input  wire logic [LW-1:0]     head_len,
    input  wire logic              head_ovf,
    output logic                   pop,
    output logic      [PW:0]       rd_addr,
    input  wire logic [QUAL_W-1:0] rd_data,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic      [KEEP_W-1:0] keep_length,
    output logic                   too_long
);

`include "quality_tail_trim_assert.svh"

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_SCAN = 1'b1;

    logic              state_reg, state_next;
    logic [PW-1:0]     pos_reg, pos_next;
    logic [SUM_W-1:0]  run_reg, run_next;
    logic [SUM_W-1:0]  best_reg, best_next;
    logic [LW-1:0]     best_len_reg, best_len_next;
    logic              out_valid_reg, out_valid_next;
    logic [KEEP_W-1:0] keep_reg, keep_next;
    logic              too_long_reg, too_long_next;

    logic              start;
    logic              no_steps;
    logic [LW-1:0]     len_m1;
    logic [SUM_W:0]    step_w;
    logic [SUM_W:0]    sum_w;
    logic              sum_neg;
    logic [SUM_W-1:0]  sum_sat;
    logic              improve;
    logic [LW-1:0]     best_len_upd;
    logic              at_floor;
    logic              done;

    assign start    = (state_reg == ST_IDLE) && head_valid && !out_valid_reg;
    assign no_steps = CMPW'(min_keep_length) >= CMPW'(head_len);
    assign len_m1   = head_len - LW'(1);

    // Step value is threshold - (q - 33); it may be negative.
    assign step_w  = (SUM_W+1)'(quality_threshold) + PHRED_OFFSET - (SUM_W+1)'(rd_data);
    assign sum_w   = {1'b0, run_reg} + step_w;
    assign sum_neg = sum_w[SUM_W];
    assign sum_sat = sum_w[SUM_W-1] ? SUM_MAX : sum_w[SUM_W-1:0];
    assign improve = !sum_neg && (sum_sat > best_reg);
    assign best_len_upd = improve ? LW'(pos_reg) : best_len_reg;
    assign at_floor = CMPW'(pos_reg) == CMPW'(min_keep_length);
    assign done     = (state_reg == ST_SCAN) && (sum_neg || at_floor);

    assign pop = (start && no_steps) || done;

    always_comb
    begin
        if (state_reg == ST_SCAN)
        begin
            rd_addr = {head_bank, pos_reg - PW'(1)};
        end
        else
        begin
            rd_addr = {head_bank, len_m1[PW-1:0]};
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        pos_next       = pos_reg;
        run_next       = run_reg;
        best_next      = best_reg;
        best_len_next  = best_len_reg;
        out_valid_next = out_valid_reg && !out_ready;
        keep_next      = keep_reg;
        too_long_next  = too_long_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    if (no_steps)
                    begin
                        out_valid_next = 1'b1;
                        keep_next      = KEEP_W'(head_len);
                        too_long_next  = head_ovf;
                    end
                    else
                    begin
                        state_next    = ST_SCAN;
                        pos_next      = len_m1[PW-1:0];
                        run_next      = '0;
                        best_next     = '0;
                        best_len_next = head_len;
                    end
                end
            end
            ST_SCAN:
            begin
                run_next      = sum_sat;
                best_next     = improve ? sum_sat : best_reg;
                best_len_next = best_len_upd;
                pos_next      = pos_reg - PW'(1);
                if (done)
                begin
                    state_next     = ST_IDLE;
                    out_valid_next = 1'b1;
                    keep_next      = KEEP_W'(best_len_upd);
                    too_long_next  = head_ovf;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        pos_reg      <= pos_next;
        run_reg      <= run_next;
        best_reg     <= best_next;
        best_len_reg <= best_len_next;
        keep_reg     <= keep_next;
        too_long_reg <= too_long_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign keep_length = keep_reg;
    assign too_long    = too_long_reg;

    `QTT_ASSERT_NOW(a_scan_has_job, state_reg == ST_SCAN, head_valid)
    `QTT_ASSERT_NOW(a_result_idle, out_valid_reg, state_reg == ST_IDLE)
    `QTT_ASSERT_NEXT(a_done_shows, done, out_valid_reg && (state_reg == ST_IDLE))

endmodule

`default_nettype wire

// ----- dv/quality_tail_trim_tb.sv -----
// ----------------------------------------------------------------------------
// quality_tail_trim_tb
// Self-checking bench for the quality tail trimmer. Reads of quality bytes
// go in through the request channel. Every result is compared field by field
// with a hand-typed result from the table or a trim point worked out from the
// bench's copy of the read and of the threshold and minimum-length registers.
// ----------------------------------------------------------------------------

module quality_tail_trim_tb;
    import qtt_pkg::*;

    // One expected result: the kept length and the truncation flag.
    typedef struct packed {
        logic [KEEP_W-1:0] keep;
        logic              too_long;
    } trim_result_t;

    // Rows of the directed table either send one quality byte or write one
    // register. A byte row that ends a read may carry a hand-typed result.
    typedef enum logic [1:0] {
        ROW_BYTE,
        ROW_SET_THRESHOLD,
        ROW_SET_MIN_KEEP
    } row_kind_e;

    typedef struct packed {
        row_kind_e         kind;
        logic [10:0]       value;
        logic              lst;
        logic              typed;
        logic [KEEP_W-1:0] keep;
        logic              too_long;
    } stim_row_t;

    localparam int DIRECTED_ROWS = 25;
    localparam int RANDOM_BYTES  = 2000;
    localparam int PHASE_BYTES   = 120;

    // Walked top to bottom right after reset, with both registers at zero.
    localparam stim_row_t DIRECTED [DIRECTED_ROWS] = '{
        // Reset state: zero threshold, a code of 33 adds nothing; keep it all.
        '{ROW_BYTE,          11'd33,   1'b1, 1'b1, 11'd1, 1'b0},
        '{ROW_SET_THRESHOLD, 11'd93,   1'b0, 1'b0, 11'd0, 1'b0},
        // Both byte extremes in one read; a quality code below 33 adds more
        // than the threshold to the sum.
        '{ROW_BYTE,          11'd0,    1'b0, 1'b0, 11'd0, 1'b0},
        '{ROW_BYTE,          11'd255,  1'b0, 1'b0, 11'd0, 1'b0},
        '{ROW_BYTE,          11'd33,   1'b1, 1'b0, 11'd0, 1'b0},
        // A top quality byte drives the sum negative at once: keep it.
        '{ROW_BYTE,          11'd255,  1'b1, 1'b1, 11'd1, 1'b0},
        // A byte below the offset is trimmed away completely.
        '{ROW_BYTE,          11'd0,    1'b1, 1'b1, 11'd0, 1'b0},
        // Minimum above the read length: nothing is scanned.
        '{ROW_SET_MIN_KEEP,  11'd1024, 1'b0, 1'b0, 11'd0, 1'b0},
        '{ROW_BYTE,          11'd0,    1'b0, 1'b0, 11'd0, 1'b0},
        '{ROW_BYTE,          11'd0,    1'b0, 1'b0, 11'd0, 1'b0},
        '{ROW_BYTE,          11'd0,    1'b1, 1'b1, 11'd3, 1'b0},
        // The scan must stop at the minimum even while the sum still grows.
        '{ROW_SET_MIN_KEEP,  11'd2,    1'b0, 1'b0, 11'd0, 1'b0},
        '{ROW_BYTE,          11'd0,    1'b0, 1'b0, 11'd0, 1'b0},
        '{ROW_BYTE,          11'd0,    1'b0, 1'b0, 11'd0, 1'b0},
        '{ROW_BYTE,          11'd0,    1'b0, 1'b0, 11'd0, 1'b0},
        '{ROW_BYTE,          11'd200,  1'b1, 1'b0, 11'd0, 1'b0},
        '{ROW_BYTE,          11'd0,    1'b0, 1'b0, 11'd0, 1'b0},
        '{ROW_BYTE,          11'd0,    1'b0, 1'b0, 11'd0, 1'b0},
        '{ROW_BYTE,          11'd0,    1'b0, 1'b0, 11'd0, 1'b0},
        '{ROW_BYTE,          11'd0,    1'b1, 1'b0, 11'd0, 1'b0},
        // Back to zero threshold and minimum; the scan reaches position 0.
        '{ROW_SET_THRESHOLD, 11'd0,    1'b0, 1'b0, 11'd0, 1'b0},
        '{ROW_SET_MIN_KEEP,  11'd0,    1'b0, 1'b0, 11'd0, 1'b0},
        '{ROW_BYTE,          11'd40,   1'b0, 1'b0, 11'd0, 1'b0},
        '{ROW_BYTE,          11'd30,   1'b0, 1'b0, 11'd0, 1'b0},
        '{ROW_BYTE,          11'd33,   1'b1, 1'b0, 11'd0, 1'b0}
    };

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  in_valid;
    logic                  in_ready;
    logic [QUAL_W-1:0]     qual_byte;
    logic                  last;
    logic                  out_valid;
    logic                  out_ready;
    logic [KEEP_W-1:0]     keep_length;
    logic                  too_long;

    // Bench copy of the block's state: the bytes of the read in flight, how
    // many were stored, whether any were dropped, and both registers.
    logic [QUAL_W-1:0] read_bytes [QTT_MAX_READ_LEN];
    int                read_fill;
    bit                read_truncated;
    logic [THR_W-1:0]  cur_threshold;
    logic [KEEP_W-1:0] cur_min_keep;

    trim_result_t pending_trims[$];
    int           mismatches;
    int           send_idle_pct;
    int           recv_stall_pct;

    quality_tail_trim u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .qual_byte   (qual_byte),
        .last        (last),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .keep_length (keep_length),
        .too_long    (too_long)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // Backward scan over the stored read. The running sum gains the threshold
    // minus the Phred value at each step, so a low-quality tail pushes it up.
    // The scan quits when the sum turns negative or the minimum is passed;
    // the kept length is the position of the highest sum above zero.
    function automatic logic [KEEP_W-1:0] trim_point();
        int  pos;
        int  phred;
        int  sum;
        int  best_sum;
        int  best_len;
        bit  stopped;
        sum      = 0;
        best_sum = 0;
        best_len = read_fill;
        stopped  = 1'b0;
        for (pos = read_fill - 1; !stopped && pos >= int'(cur_min_keep) && pos >= 0; pos--)
        begin
            phred = int'(read_bytes[pos]) - int'(PHRED_OFFSET);
            sum   = sum + int'(cur_threshold) - phred;
            if (sum > int'(SUM_MAX))
            begin
                sum = int'(SUM_MAX);
            end
            if (sum < 0)
            begin
                stopped = 1'b1;
            end
            else if (sum > best_sum)
            begin
                best_sum = sum;
                best_len = pos;
            end
        end
        return KEEP_W'(best_len);
    endfunction

    // Called once per accepted request. A final byte closes the read and
    // queues its result; a typed result from the table replaces the computed
    // one but the read state is advanced all the same.
    task automatic take_byte(input logic [QUAL_W-1:0] qb, input logic lst,
                             input logic typed, input logic [KEEP_W-1:0] typed_keep,
                             input logic typed_too_long);
        trim_result_t res;
        if (read_fill < QTT_MAX_READ_LEN)
        begin
            read_bytes[read_fill] = qb;
            read_fill++;
        end
        else
        begin
            read_truncated = 1'b1;
        end
        if (lst)
        begin
            if (typed)
            begin
                res.keep     = typed_keep;
                res.too_long = typed_too_long;
            end
            else
            begin
                res.keep     = trim_point();
                res.too_long = read_truncated;
            end
            pending_trims.push_back(res);
            read_fill      = 0;
            read_truncated = 1'b0;
        end
    endtask

    // Entered and left at a falling edge. The sender may sit idle first,
    // then holds the request until the block takes it at a rising edge.
    task automatic send_byte(input logic [QUAL_W-1:0] qb, input logic lst,
                             input logic typed, input logic [KEEP_W-1:0] typed_keep,
                             input logic typed_too_long);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            @(negedge clk);
        end
        in_valid  = 1'b1;
        qual_byte = qb;
        last      = lst;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
        take_byte(qb, lst, typed, typed_keep, typed_too_long);
        @(negedge clk);
        in_valid = 1'b0;
    endtask

    // Every result has come back once nothing is pending, which also means
    // the scan is over; the bench then waits on to cover any internal turnaround.
    task automatic wait_until_idle();
        while (pending_trims.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (4) @(negedge clk);
    endtask

    // Registers change only with the block idle, so the bench copy can be
    // updated at the same moment.
    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] val);
        wait_until_idle();
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        @(negedge clk);
        cfg_we = 1'b0;
        if (idx == REG_QUALITY_THRESHOLD)
        begin
            cur_threshold = val[THR_W-1:0];
        end
        else if (idx == REG_MIN_KEEP_LENGTH)
        begin
            cur_min_keep = val[KEEP_W-1:0];
        end
    endtask

    // A well-formed read has a good head and a tail at or below the
    // threshold, with the knee anywhere. noise_pct of the bytes are arbitrary
    // codes, including ones below the Phred offset.
    task automatic send_read(input int len, input int noise_pct);
        int               knee;
        int               i;
        int               phred;
        logic [QUAL_W-1:0] qb;
        knee = $urandom_range(0, len);
        for (i = 0; i < len; i++)
        begin
            if ($urandom_range(0, 99) < noise_pct)
            begin
                qb = QUAL_W'($urandom_range(0, 255));
            end
            else
            begin
                if (i < knee)
                begin
                    phred = $urandom_range(int'(cur_threshold), 93);
                end
                else
                begin
                    phred = $urandom_range(0, int'(cur_threshold));
                end
                qb = QUAL_W'(phred + int'(PHRED_OFFSET));
            end
            send_byte(qb, i == len - 1, 1'b0, '0, 1'b0);
        end
    endtask

    task automatic set_idle_mode(input int mode);
        case (mode)
            0:
            begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
            1:
            begin
                send_idle_pct  = 70;
                recv_stall_pct = 0;
            end
            2:
            begin
                send_idle_pct  = 0;
                recv_stall_pct = 70;
            end
            default:
            begin
                send_idle_pct  = 17;
                recv_stall_pct = 17;
            end
        endcase
    endtask

    // Receiver: out_ready changes at the falling edge only.
    always @(negedge clk)
    begin
        out_ready = ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // Result checker: each accepted result against the oldest expectation.
    always @(posedge clk)
    begin : result_check
        trim_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_trims.size() == 0)
            begin
                $error("result with none expected: keep_length %0d, too_long %0d",
                       keep_length, too_long);
                mismatches++;
            end
            else
            begin
                want = pending_trims.pop_front();
                if (keep_length !== want.keep)
                begin
                    $error("keep_length: expected %0d, actual %0d", want.keep, keep_length);
                    mismatches++;
                end
                if (too_long !== want.too_long)
                begin
                    $error("too_long: expected %0d, actual %0d", want.too_long, too_long);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog, far above the slowest legal run of this stimulus.
    initial
    begin
        #(12 * 400000);
        $display("quality_tail_trim: mismatch");
        $finish;
    end

    initial
    begin : stimulus
        int r;
        int phase;
        int sent;
        int phase_bytes;
        int len;
        int thr;
        int min_len;

        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        in_valid       = 1'b0;
        qual_byte      = '0;
        last           = 1'b0;
        out_ready      = 1'b0;
        mismatches     = 0;
        read_fill      = 0;
        read_truncated = 1'b0;
        cur_threshold  = '0;
        cur_min_keep   = '0;
        set_idle_mode(0);

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed table.
        for (r = 0; r < DIRECTED_ROWS; r++)
        begin
            case (DIRECTED[r].kind)
                ROW_SET_THRESHOLD:
                begin
                    write_register(REG_QUALITY_THRESHOLD, DIRECTED[r].value);
                end
                ROW_SET_MIN_KEEP:
                begin
                    write_register(REG_MIN_KEEP_LENGTH, DIRECTED[r].value);
                end
                default:
                begin
                    send_byte(DIRECTED[r].value[QUAL_W-1:0], DIRECTED[r].lst,
                              DIRECTED[r].typed, DIRECTED[r].keep, DIRECTED[r].too_long);
                end
            endcase
        end

        // Random phases. Each one drains, so the sender pauses until every
        // result is back, then rewrites both registers and picks an idle mode.
        // Phase 0 runs the highest threshold, phase 1 the largest minimum,
        // and phase 5 sends one read just past the store size with a zero
        // threshold, so the whole store is kept and the overflow flag shows.
        phase = 0;
        sent  = 0;
        while (sent < RANDOM_BYTES)
        begin
            set_idle_mode(phase % 4);
            if (phase == 0)
            begin
                thr = 93;
            end
            else if (phase == 5)
            begin
                thr = 0;
            end
            else
            begin
                thr = $urandom_range(0, 93);
            end
            if (phase == 1)
            begin
                min_len = 1024;
            end
            else if (phase == 0 || phase == 5)
            begin
                min_len = 0;
            end
            else if ($urandom_range(0, 3) == 0)
            begin
                min_len = $urandom_range(0, 1024);
            end
            else
            begin
                min_len = $urandom_range(0, 12);
            end
            write_register(REG_QUALITY_THRESHOLD, CFG_DATA_W'(thr));
            write_register(REG_MIN_KEEP_LENGTH, CFG_DATA_W'(min_len));

            phase_bytes = 0;
            if (phase == 5)
            begin
                send_read(QTT_MAX_READ_LEN + 1, 0);
                phase_bytes = QTT_MAX_READ_LEN + 1;
            end
            while (phase_bytes < PHASE_BYTES)
            begin
                if ($urandom_range(0, 9) == 0)
                begin
                    len = $urandom_range(41, 200);
                end
                else
                begin
                    len = $urandom_range(1, 40);
                end
                // A few reads are pure noise; the rest are shaped.
                if ($urandom_range(0, 19) == 0)
                begin
                    send_read(len, 100);
                end
                else
                begin
                    send_read(len, 10);
                end
                phase_bytes += len;
            end
            sent += phase_bytes;
            phase++;
        end

        wait_until_idle();
        repeat (40) @(negedge clk);
        if (mismatches == 0)
        begin
            $display("quality_tail_trim: match");
        end
        else
        begin
            $display("quality_tail_trim: mismatch");
        end
        $finish;
    end

endmodule
